/* design/i2cm_pkg.sv */
// Shared types and constants for the I2C master byte engine.
// No dependencies.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0]  HALF_PERIOD_RST = 8'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_STOP     = 3'd1;
  localparam logic [2:0] KIND_WRITE    = 3'd2;
  localparam logic [2:0] KIND_READ     = 3'd3;
  localparam logic [2:0] KIND_WAIT_ACK = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
    PH_WR_LO, PH_WR_HI, PH_WR_END,
    PH_RD_LO, PH_RD_HI, PH_RD_END, PH_AK_SET, PH_AK_HI,
    PH_WA_REL, PH_WA_POLL, PH_WA_LO, PH_WA_SPA, PH_WA_SPB
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [7:0]  tick_timer;
    logic [15:0] poll_count;
    logic        scl_level;
    logic        sda_level;
    logic        nack_flag;
    logic        ack_choice;
    logic [7:0]  rd_byte;
  } state_t;

  typedef struct packed {
    logic [7:0]  half_period_ticks;
    logic [15:0] ack_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] wr_data;
    logic       send_nack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_failed;
  } out_item_t;

endpackage
`default_nettype wire

/* design/i2cm_step.sv */
// Per-tick next-state and result logic of the I2C master sequencer.
// Depends on i2cm_pkg.
`default_nettype none
module i2cm_step (
  input  i2cm_pkg::state_t    state_i,
  input  i2cm_pkg::cfg_t      cfg_i,
  input  i2cm_pkg::in_item_t  item_i,
  output i2cm_pkg::state_t    state_o,
  output i2cm_pkg::out_item_t result_o
);
  import i2cm_pkg::*;

  logic [7:0] tmr_load;
  logic [3:0] bit_inc;
  logic       done;
  state_t     nx;

  assign tmr_load = (cfg_i.half_period_ticks == 8'd0) ? 8'd1 : cfg_i.half_period_ticks;
  assign bit_inc  = state_i.bit_index + 4'd1;

  function automatic state_t enter_ph(state_t s, phase_e p, logic scl, logic sda,
                                      logic [7:0] tmr);
    state_t r;
    r = s;
    r.phase      = p;
    r.scl_level  = scl;
    r.sda_level  = sda;
    r.tick_timer = tmr;
    return r;
  endfunction

  always_comb begin
    nx   = state_i;
    done = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      if (item_i.cmd_valid) begin
        nx.bit_index = 4'd0;
        case (item_i.kind)
          KIND_START: nx = enter_ph(nx, PH_ST_A, 1'b1, 1'b1, tmr_load);
          KIND_STOP:  nx = enter_ph(nx, PH_SP_A, 1'b1, 1'b0, tmr_load);
          KIND_WRITE: begin
            nx.shift_byte = {item_i.wr_data[6:0], 1'b0};
            nx = enter_ph(nx, PH_WR_LO, 1'b0, item_i.wr_data[7], tmr_load);
          end
          KIND_READ: begin
            nx.ack_choice = item_i.send_nack;
            nx.shift_byte = 8'd0;
            nx = enter_ph(nx, PH_RD_LO, 1'b0, 1'b1, tmr_load);
          end
          KIND_WAIT_ACK: begin
            nx.nack_flag  = 1'b0;
            nx.poll_count = 16'd0;
            nx = enter_ph(nx, PH_WA_REL, 1'b1, 1'b1, tmr_load);
          end
          default: ;
        endcase
      end
    end else if (state_i.phase == PH_WA_POLL) begin
      if (!item_i.sda_in) begin
        nx = enter_ph(nx, PH_WA_LO, 1'b0, 1'b1, tmr_load);
      end else if (state_i.poll_count >= cfg_i.ack_timeout_ticks) begin
        nx = enter_ph(nx, PH_WA_SPA, 1'b1, 1'b0, tmr_load);
      end else begin
        nx.poll_count = state_i.poll_count + 16'd1;
      end
    end else if (state_i.tick_timer > 8'd1) begin
      nx.tick_timer = state_i.tick_timer - 8'd1;
    end else begin
      unique case (state_i.phase)
        PH_ST_A: nx = enter_ph(nx, PH_ST_B, 1'b1, 1'b0, tmr_load);
        PH_ST_B: begin
          nx.scl_level = 1'b0;
          nx.phase     = PH_IDLE;
          done         = 1'b1;
        end
        PH_SP_A: nx = enter_ph(nx, PH_SP_B, 1'b1, 1'b1, tmr_load);
        PH_SP_B, PH_WR_END, PH_WA_LO: begin
          nx.phase = PH_IDLE;
          done     = 1'b1;
        end
        PH_WR_LO: nx = enter_ph(nx, PH_WR_HI, 1'b1, state_i.sda_level, tmr_load);
        PH_WR_HI: begin
          nx.bit_index = bit_inc;
          if (bit_inc < 4'(BITS_PER_BYTE)) begin
            nx.shift_byte = {state_i.shift_byte[6:0], 1'b0};
            nx = enter_ph(nx, PH_WR_LO, 1'b0, state_i.shift_byte[7], tmr_load);
          end else begin
            nx = enter_ph(nx, PH_WR_END, 1'b0, state_i.sda_level, tmr_load);
          end
        end
        PH_RD_LO: nx = enter_ph(nx, PH_RD_HI, 1'b1, 1'b1, tmr_load);
        PH_RD_HI: begin
          nx.shift_byte = {state_i.shift_byte[6:0], item_i.sda_in};
          nx.bit_index  = bit_inc;
          if (bit_inc < 4'(BITS_PER_BYTE)) begin
            nx = enter_ph(nx, PH_RD_LO, 1'b0, 1'b1, tmr_load);
          end else begin
            nx.rd_byte = {state_i.shift_byte[6:0], item_i.sda_in};
            nx = enter_ph(nx, PH_RD_END, 1'b0, 1'b1, tmr_load);
          end
        end
        PH_RD_END: nx = enter_ph(nx, PH_AK_SET, 1'b0, state_i.ack_choice, tmr_load);
        PH_AK_SET: nx = enter_ph(nx, PH_AK_HI, 1'b1, state_i.ack_choice, tmr_load);
        PH_AK_HI: begin
          nx.scl_level = 1'b0;
          nx.phase     = PH_IDLE;
          done         = 1'b1;
        end
        PH_WA_REL: nx.phase = PH_WA_POLL;
        PH_WA_SPA: nx = enter_ph(nx, PH_WA_SPB, 1'b1, 1'b1, tmr_load);
        PH_WA_SPB: begin
          nx.nack_flag = 1'b1;
          nx.phase     = PH_IDLE;
          done         = 1'b1;
        end
        default: nx.phase = PH_IDLE;
      endcase
    end
  end

  assign state_o = nx;

  always_comb begin
    result_o.scl_out    = nx.scl_level;
    result_o.sda_out    = nx.sda_level;
    result_o.busy_res   = (nx.phase != PH_IDLE);
    result_o.done_res   = done;
    result_o.rd_data    = nx.rd_byte;
    result_o.ack_failed = nx.nack_flag;
  end

endmodule
`default_nettype wire

/* design/i2c_master_byte_engine.sv */
// I2C master byte engine, top level: sequencer state, config registers, result register.
// Result: the result of a tick is registered and appears in the cycle after its transfer is accepted.
// Throughput: one tick per cycle unless out_ready_i holds the result register; a new transfer is taken while it drains.
// Reset: idle, SCL and SDA released, read byte and flags zero, half period 5, timeout 250.
// Depends on i2cm_pkg and i2cm_step.
`default_nettype none
module i2c_master_byte_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i
);
  import i2cm_pkg::*;

  state_t    state_q, state_d;
  cfg_t      cfg_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  i2cm_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, bit_index: 4'd0, shift_byte: 8'd0, tick_timer: 8'd0,
                       poll_count: 16'd0, scl_level: 1'b1, sda_level: 1'b1,
                       nack_flag: 1'b0, ack_choice: 1'b0, rd_byte: 8'd0};
      cfg_q       <= '{half_period_ticks: HALF_PERIOD_RST, ack_timeout_ticks: ACK_TIMEOUT_RST};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata_i[7:0];
          CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_wdata_i;
        endcase
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !(out_q.done_res && out_q.busy_res))
    else $error("done and busy reported together");

  a_bit_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_index <= 4'(BITS_PER_BYTE))
    else $error("bit index beyond byte");

  a_timer_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_IDLE && state_q.phase != PH_WA_POLL) |-> state_q.tick_timer != 8'd0)
    else $error("timed phase with empty timer");
`endif

endmodule
`default_nettype wire
